// ===== design/rectangle_table_hit_test_core_assert.svh =====
// Assertion helpers shared by the block's modules.
`ifndef RECTANGLE_TABLE_HIT_TEST_CORE_ASSERT_SVH
`define RECTANGLE_TABLE_HIT_TEST_CORE_ASSERT_SVH

// Holds at every clock edge outside reset.
`define RTHT_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("rtht check failed");

// Consequent holds in the same cycle as the antecedent.
`define RTHT_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rtht check failed");

// Consequent holds in the cycle after the antecedent.
`define RTHT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rtht check failed");

`endif

// ===== design/rtht_pkg.sv =====
package rtht_pkg;

   localparam int DEF_MAX_BOXES  = 16;
   localparam int DEF_COORD_BITS = 9;
   localparam int MAX_RESULTS    = 16;
   localparam int RES_BITS       = $clog2(MAX_RESULTS + 1);
   localparam int CALC_BITS      = 18;

   localparam int ACTION_BITS   = 2;
   localparam int POS_BITS      = 10;
   localparam int SPAN_BITS     = 9;
   localparam int CHAR_BITS     = 8;
   localparam int ATTR_BITS     = 16;
   localparam int STATUS_BITS   = 3;
   localparam int INDEX_BITS    = 4;
   localparam int BOX_BITS      = 9;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 9;

   localparam logic [ACTION_BITS-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_FIND   = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_ZONE   = 2'd2;
   localparam logic [ACTION_BITS-1:0] ACT_POINT  = 2'd3;

   localparam logic [STATUS_BITS-1:0] STAT_STORED   = 3'd0;
   localparam logic [STATUS_BITS-1:0] STAT_RANGE    = 3'd1;
   localparam logic [STATUS_BITS-1:0] STAT_FULL     = 3'd2;
   localparam logic [STATUS_BITS-1:0] STAT_MATCH    = 3'd3;
   localparam logic [STATUS_BITS-1:0] STAT_NO_MATCH = 3'd4;

   localparam logic [CSR_IDX_BITS-1:0] REG_LIMIT_X = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] REG_LIMIT_Y = 1'b1;

   localparam logic [CSR_DATA_BITS-1:0] LIMIT_X_RESET = 9'd120;
   localparam logic [CSR_DATA_BITS-1:0] LIMIT_Y_RESET = 9'd60;

   typedef logic signed [CALC_BITS-1:0] calc_type;

   localparam calc_type CALC_ZERO = '0;
   localparam calc_type CALC_ONE  = calc_type'(1);

   typedef struct packed {
      logic [ACTION_BITS-1:0]     action;
      logic signed [POS_BITS-1:0] pos_x;
      logic signed [POS_BITS-1:0] pos_y;
      logic [SPAN_BITS-1:0]       span_w;
      logic [SPAN_BITS-1:0]       span_h;
   } rtht_query_type;

   typedef struct packed {
      logic signed [POS_BITS-1:0] pos_x;
      logic signed [POS_BITS-1:0] pos_y;
      logic [SPAN_BITS-1:0]       span_w;
      logic [SPAN_BITS-1:0]       span_h;
      logic [CHAR_BITS-1:0]       fill_char;
      logic [ATTR_BITS-1:0]       color_attr;
   } rtht_entry_type;

   typedef struct packed {
      logic                 hit;
      logic [BOX_BITS-1:0]  box_x;
      logic [BOX_BITS-1:0]  box_y;
      logic [BOX_BITS-1:0]  box_width;
      logic [BOX_BITS-1:0]  box_height;
      logic [CHAR_BITS-1:0] box_char;
      logic [ATTR_BITS-1:0] box_attr;
   } rtht_hit_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [INDEX_BITS-1:0]  entry_index;
      logic [BOX_BITS-1:0]    box_x;
      logic [BOX_BITS-1:0]    box_y;
      logic [BOX_BITS-1:0]    box_width;
      logic [BOX_BITS-1:0]    box_height;
      logic [CHAR_BITS-1:0]   box_char;
      logic [ATTR_BITS-1:0]   box_attr;
      logic                   last;
   } rtht_rsp_type;

   typedef struct packed {
      logic launch;   // query enters cell 0
      logic advance;  // whole chain shifts one cell
      logic flush;    // drop the token
   } rtht_chain_ctl_type;

   function automatic calc_type sext_pos(input logic [POS_BITS-1:0] v);
      return {{(CALC_BITS-POS_BITS){v[POS_BITS-1]}}, v};
   endfunction

   function automatic calc_type zext_span(input logic [SPAN_BITS-1:0] v);
      return {{(CALC_BITS-SPAN_BITS){1'b0}}, v};
   endfunction

   function automatic logic in_span(input calc_type d, input calc_type s);
      return (d >= CALC_ZERO) && (d <= s);
   endfunction

endpackage

// ===== design/rtht_req_if.sv =====
interface rtht_req_if;
   import rtht_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [ACTION_BITS-1:0]     action;
   logic signed [POS_BITS-1:0] pos_x;
   logic signed [POS_BITS-1:0] pos_y;
   logic [SPAN_BITS-1:0]       span_w;
   logic [SPAN_BITS-1:0]       span_h;
   logic [CHAR_BITS-1:0]       fill_char;
   logic [ATTR_BITS-1:0]       color_attr;

   modport source (output valid, action, pos_x, pos_y, span_w, span_h, fill_char,
                   color_attr, input ready);
   modport sink   (input valid, action, pos_x, pos_y, span_w, span_h, fill_char,
                   color_attr, output ready);
endinterface

// ===== design/rtht_rsp_if.sv =====
interface rtht_rsp_if;
   import rtht_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [INDEX_BITS-1:0]  entry_index;
   logic [BOX_BITS-1:0]    box_x;
   logic [BOX_BITS-1:0]    box_y;
   logic [BOX_BITS-1:0]    box_width;
   logic [BOX_BITS-1:0]    box_height;
   logic [CHAR_BITS-1:0]   box_char;
   logic [ATTR_BITS-1:0]   box_attr;
   logic                   last;

   modport source (output valid, status, entry_index, box_x, box_y, box_width,
                   box_height, box_char, box_attr, last, input ready);
   modport sink   (input valid, status, entry_index, box_x, box_y, box_width,
                   box_height, box_char, box_attr, last, output ready);
endinterface

// ===== design/rtht_cell.sv =====
module rtht_cell #(
   parameter int COORD_BITS = rtht_pkg::DEF_COORD_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rtht_pkg::rtht_chain_ctl_type ctl,
   input  logic                        prev_valid,
   input  rtht_pkg::rtht_query_type    prev_query,
   input  logic                        wr_en,
   input  rtht_pkg::rtht_entry_type    wr_data,
   output logic                        next_valid,
   output rtht_pkg::rtht_query_type    next_query,
   output rtht_pkg::rtht_hit_type      hit
);
   import rtht_pkg::*;

   logic                  valid_ff;
   rtht_query_type        query_ff;
   logic [COORD_BITS-1:0] corner_x_ff;
   logic [COORD_BITS-1:0] corner_y_ff;
   logic [SPAN_BITS-1:0]  width_ff;
   logic [SPAN_BITS-1:0]  height_ff;
   logic [CHAR_BITS-1:0]  char_ff;
   logic [ATTR_BITS-1:0]  attr_ff;

   calc_type cx, cy, cw, ch, qx, qy, qw, qh;
   calc_type x_far, y_far;
   logic     match;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.flush) begin
         valid_ff <= 1'b0;
      end else if (ctl.advance) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         query_ff <= prev_query;
      end
      if (wr_en) begin
         corner_x_ff <= COORD_BITS'($unsigned(wr_data.pos_x));
         corner_y_ff <= COORD_BITS'($unsigned(wr_data.pos_y));
         width_ff    <= wr_data.span_w;
         height_ff   <= wr_data.span_h;
         char_ff     <= wr_data.fill_char;
         attr_ff     <= wr_data.color_attr;
      end
   end

   always_comb begin
      cx    = {{(CALC_BITS-COORD_BITS){1'b0}}, corner_x_ff};
      cy    = {{(CALC_BITS-COORD_BITS){1'b0}}, corner_y_ff};
      cw    = zext_span(width_ff);
      ch    = zext_span(height_ff);
      qx    = sext_pos(query_ff.pos_x);
      qy    = sext_pos(query_ff.pos_y);
      qw    = zext_span(query_ff.span_w);
      qh    = zext_span(query_ff.span_h);
      // far corner; a zero size puts it one before the near corner
      x_far = cx + cw - CALC_ONE;
      y_far = cy + ch - CALC_ONE;
      case (query_ff.action)
         ACT_FIND:  match = (cx == qx) && (cy == qy);
         ACT_ZONE:  match = (in_span(cx - qx, qw + CALC_ONE) ||
                             in_span(x_far - qx, qw + CALC_ONE)) &&
                            (in_span(cy - qy, qh + CALC_ONE) ||
                             in_span(y_far - qy, qh + CALC_ONE));
         ACT_POINT: match = in_span(qx - cx, cw) && in_span(qy - cy, ch);
         default:   match = 1'b0;
      endcase
   end

   // gated by the token so the row can be OR-ed together
   always_comb begin
      hit.hit        = valid_ff && match;
      hit.box_x      = valid_ff ? BOX_BITS'(corner_x_ff) : '0;
      hit.box_y      = valid_ff ? BOX_BITS'(corner_y_ff) : '0;
      hit.box_width  = valid_ff ? width_ff : '0;
      hit.box_height = valid_ff ? height_ff : '0;
      hit.box_char   = valid_ff ? char_ff : '0;
      hit.box_attr   = valid_ff ? attr_ff : '0;
   end

   assign next_valid = valid_ff;
   assign next_query = query_ff;

endmodule

// ===== design/rtht_ctrl.sv =====
`include "rectangle_table_hit_test_core_assert.svh"

module rtht_ctrl #(
   parameter int MAX_BOXES  = rtht_pkg::DEF_MAX_BOXES,
   parameter int COORD_BITS = rtht_pkg::DEF_COORD_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [rtht_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [rtht_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   rtht_req_if.sink                              req_ch,
   rtht_rsp_if.source                            rsp_ch,
   input  rtht_pkg::rtht_hit_type                hit_bus,
   output rtht_pkg::rtht_chain_ctl_type          chain_ctl,
   output rtht_pkg::rtht_query_type              head_query,
   output logic [MAX_BOXES-1:0]                  wr_sel,
   output rtht_pkg::rtht_entry_type              wr_data
);
   import rtht_pkg::*;

   localparam int CNT_W = $clog2(MAX_BOXES + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_BOXES);
   localparam logic [RES_BITS-1:0] RES_LIMIT = RES_BITS'(MAX_RESULTS);
   localparam calc_type COORD_MAX = {{(CALC_BITS-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [RES_BITS-1:0]    nres_ff, nres_in;
   logic                   find_ff, find_in;
   logic                   pend_valid_ff, pend_valid_in;
   rtht_rsp_type           pend_ff, pend_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rtht_rsp_type           rsp_ff, rsp_in;
   logic [CSR_DATA_BITS-1:0] limit_x_ff, limit_y_ff;

   logic         accept, out_free, scan_end, step, wr_go, range_ok;
   calc_type     qx, qy;
   rtht_rsp_type hit_rec, empty_rec, store_rec;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign scan_end     = (idx_ff == count_ff) || (nres_ff == RES_LIMIT);
   assign step         = (state_ff == ST_SCAN) && !scan_end && out_free;

   assign head_query.action = req_ch.action;
   assign head_query.pos_x  = req_ch.pos_x;
   assign head_query.pos_y  = req_ch.pos_y;
   assign head_query.span_w = req_ch.span_w;
   assign head_query.span_h = req_ch.span_h;

   assign wr_data.pos_x      = req_ch.pos_x;
   assign wr_data.pos_y      = req_ch.pos_y;
   assign wr_data.span_w     = req_ch.span_w;
   assign wr_data.span_h     = req_ch.span_h;
   assign wr_data.fill_char  = req_ch.fill_char;
   assign wr_data.color_attr = req_ch.color_attr;

   assign chain_ctl.launch  = accept && (req_ch.action != ACT_INSERT);
   assign chain_ctl.advance = chain_ctl.launch || step;
   assign chain_ctl.flush   = (state_ff == ST_FINISH);

   always_comb begin
      qx       = sext_pos(req_ch.pos_x);
      qy       = sext_pos(req_ch.pos_y);
      range_ok = (qx >= CALC_ZERO) && (qy >= CALC_ZERO) &&
                 (qx <= zext_span(limit_x_ff)) && (qy <= zext_span(limit_y_ff)) &&
                 (qx <= COORD_MAX) && (qy <= COORD_MAX);
   end

   always_comb begin
      empty_rec = '0;

      hit_rec             = '0;
      hit_rec.status      = STAT_MATCH;
      hit_rec.entry_index = INDEX_BITS'(idx_ff);
      hit_rec.box_x       = hit_bus.box_x;
      hit_rec.box_y       = hit_bus.box_y;
      hit_rec.box_width   = hit_bus.box_width;
      hit_rec.box_height  = hit_bus.box_height;
      hit_rec.box_char    = hit_bus.box_char;
      hit_rec.box_attr    = hit_bus.box_attr;

      store_rec             = '0;
      store_rec.status      = STAT_STORED;
      store_rec.entry_index = INDEX_BITS'(count_ff);
      store_rec.box_x       = BOX_BITS'($unsigned(req_ch.pos_x));
      store_rec.box_y       = BOX_BITS'($unsigned(req_ch.pos_y));
      store_rec.box_width   = req_ch.span_w;
      store_rec.box_height  = req_ch.span_h;
      store_rec.box_char    = req_ch.fill_char;
      store_rec.box_attr    = req_ch.color_attr;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      nres_in       = nres_ff;
      find_in       = find_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_in        = rsp_ff;
      wr_go         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_ch.action == ACT_INSERT) begin
                  pend_valid_in = 1'b1;
                  state_in      = ST_FINISH;
                  if (!range_ok) begin
                     pend_in        = empty_rec;
                     pend_in.status = STAT_RANGE;
                  end else if (count_ff == FULL_COUNT) begin
                     pend_in        = empty_rec;
                     pend_in.status = STAT_FULL;
                  end else begin
                     pend_in  = store_rec;
                     wr_go    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end else begin
                  pend_valid_in = 1'b0;
                  idx_in        = '0;
                  nres_in       = '0;
                  find_in       = (req_ch.action == ACT_FIND);
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_FINISH;
            end else if (out_free) begin
               idx_in = idx_ff + CNT_W'(1);
               if (hit_bus.hit) begin
                  pend_in       = hit_rec;
                  pend_valid_in = 1'b1;
                  if (find_ff) begin
                     state_in = ST_FINISH;
                  end else begin
                     nres_in = nres_ff + RES_BITS'(1);
                     // a newer hit proves the held one is not the last
                     if (pend_valid_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = pend_ff;
                     end
                  end
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (pend_valid_ff) begin
                  rsp_in = pend_ff;
               end else begin
                  rsp_in        = empty_rec;
                  rsp_in.status = STAT_NO_MATCH;
               end
               rsp_in.last = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      for (int k = 0; k < MAX_BOXES; k++) begin
         wr_sel[k] = wr_go && (count_ff == CNT_W'(k));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         idx_ff        <= '0;
         nres_ff       <= '0;
         find_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         limit_x_ff    <= LIMIT_X_RESET;
         limit_y_ff    <= LIMIT_Y_RESET;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         nres_ff       <= nres_in;
         find_ff       <= find_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we && (csr_index == REG_LIMIT_X)) begin
            limit_x_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == REG_LIMIT_Y)) begin
            limit_y_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_ff.status;
   assign rsp_ch.entry_index = rsp_ff.entry_index;
   assign rsp_ch.box_x       = rsp_ff.box_x;
   assign rsp_ch.box_y       = rsp_ff.box_y;
   assign rsp_ch.box_width   = rsp_ff.box_width;
   assign rsp_ch.box_height  = rsp_ff.box_height;
   assign rsp_ch.box_char    = rsp_ff.box_char;
   assign rsp_ch.box_attr    = rsp_ff.box_attr;
   assign rsp_ch.last        = rsp_ff.last;

   `RTHT_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= FULL_COUNT)
   `RTHT_ASSERT_IMPLY(a_idx_bound, clock, reset, state_ff == ST_SCAN, idx_ff <= count_ff)
   `RTHT_ASSERT_IMPLY(a_mid_has_tail, clock, reset, rsp_valid_ff && !rsp_ff.last, pend_valid_ff && (state_ff != ST_IDLE))
   `RTHT_ASSERT_IMPLY(a_hit_busy, clock, reset, hit_bus.hit, state_ff != ST_IDLE)
   `RTHT_ASSERT_NEXT(a_store_grows, clock, reset, wr_go, count_ff == $past(count_ff) + CNT_W'(1))

endmodule

// ===== design/rectangle_table_hit_test_core.sv =====
// Channel   Dir  Fields                                           Transfer
// req_ch    in   action pos_x pos_y span_w span_h fill_char       valid & ready
//                color_attr
// rsp_ch    out  status entry_index box_x box_y box_width         valid & ready
//                box_height box_char box_attr last
// csr_*     in   csr_index csr_wdata                              csr_we
//
// One item at a time. Insert: the result is registered in the hold stage, then sent once rsp_ch is free.
// Queries: a token walks the row of MAX_BOXES cells, one cell per cycle, over the
// stored entries; it stops after MAX_RESULTS matches, and a find stops at its first match.
// A stalled rsp_ch freezes the walk; results go out in slot order through a
// one-deep hold stage so the final one can carry last.
// Synchronous reset empties the table, restores limits 120/60, drops the token.
`include "rectangle_table_hit_test_core_assert.svh"

module rectangle_table_hit_test_core #(
   parameter int MAX_BOXES  = rtht_pkg::DEF_MAX_BOXES,
   parameter int COORD_BITS = rtht_pkg::DEF_COORD_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [rtht_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [rtht_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   rtht_req_if.sink                           req_ch,
   rtht_rsp_if.source                         rsp_ch
);
   import rtht_pkg::*;

   rtht_chain_ctl_type chain_ctl;
   rtht_query_type     head_query;
   rtht_entry_type     wr_data;
   logic [MAX_BOXES-1:0] wr_sel;
   logic [MAX_BOXES-1:0] link_valid;
   rtht_query_type     link_query [MAX_BOXES];
   rtht_hit_type       cell_hit   [MAX_BOXES];
   rtht_hit_type       hit_bus;

   rtht_ctrl #(
      .MAX_BOXES  (MAX_BOXES),
      .COORD_BITS (COORD_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .hit_bus    (hit_bus),
      .chain_ctl  (chain_ctl),
      .head_query (head_query),
      .wr_sel     (wr_sel),
      .wr_data    (wr_data)
   );

   for (genvar k = 0; k < MAX_BOXES; k++) begin : g_cell
      logic           in_valid;
      rtht_query_type in_query;

      if (k == 0) begin : g_head
         assign in_valid = chain_ctl.launch;
         assign in_query = head_query;
      end else begin : g_link
         assign in_valid = link_valid[k-1];
         assign in_query = link_query[k-1];
      end

      rtht_cell #(
         .COORD_BITS (COORD_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (chain_ctl),
         .prev_valid (in_valid),
         .prev_query (in_query),
         .wr_en      (wr_sel[k]),
         .wr_data    (wr_data),
         .next_valid (link_valid[k]),
         .next_query (link_query[k]),
         .hit        (cell_hit[k])
      );
   end

   // only the cell holding the token drives nonzero
   always_comb begin
      hit_bus = '0;
      for (int k = 0; k < MAX_BOXES; k++) begin
         hit_bus = hit_bus | cell_hit[k];
      end
   end

   `RTHT_ASSERT_ALWAYS(a_one_token, clock, reset, $onehot0(link_valid))
   `RTHT_ASSERT_IMPLY(a_launch_empty, clock, reset, chain_ctl.launch, link_valid == '0)
   `RTHT_ASSERT_IMPLY(a_hit_has_token, clock, reset, hit_bus.hit, link_valid != '0)

endmodule
